### design/pcpt_pkg.sv
// ----------------------------------------------------------------------------
// pcpt_pkg
// Shared types and constants of the point cloud proximity test.
// ----------------------------------------------------------------------------
package pcpt_pkg;

  localparam int COORD_W = 16;
  localparam int POINT_W = 3 * COORD_W;
  localparam int LIMIT_W = 36;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 36'd65536;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_LOAD_FIRST  = 2'd0;
  localparam kind_t KIND_LOAD_SECOND = 2'd1;
  localparam kind_t KIND_TEST        = 2'd2;

  typedef struct packed {
    kind_t  kind;
    logic   last;
    coord_t x;
    coord_t y;
    coord_t z;
  } word_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

### design/pcpt_front.sv
// ----------------------------------------------------------------------------
// pcpt_front
// Input register stage: takes a word, classifies it as a load of either cloud
// or a test, and hands it to the command queue.
// ----------------------------------------------------------------------------
module pcpt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  pcpt_pkg::coord_t    in_coord_x,
  input  pcpt_pkg::coord_t    in_coord_y,
  input  pcpt_pkg::coord_t    in_coord_z,
  input  logic                in_last_point,
  input  pcpt_pkg::q_status_t q_status,
  output logic                push,
  output pcpt_pkg::word_t     push_word
);

  logic            fv_r;
  pcpt_pkg::word_t fw_r;
  pcpt_pkg::word_t fw_nxt;
  logic            take;

  assign in_stall  = fv_r && q_status.full;
  assign take      = in_valid && !in_stall;
  assign push      = fv_r && !q_status.full;
  assign push_word = fw_r;

  always_comb begin
    fw_nxt.last = in_last_point;
    fw_nxt.x    = in_coord_x;
    fw_nxt.y    = in_coord_y;
    fw_nxt.z    = in_coord_z;
    if (!in_operation) begin
      fw_nxt.kind = pcpt_pkg::KIND_LOAD_FIRST;
    end else if (in_last_point) begin
      fw_nxt.kind = pcpt_pkg::KIND_TEST;
    end else begin
      fw_nxt.kind = pcpt_pkg::KIND_LOAD_SECOND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (take) begin
      fv_r <= 1'b1;
    end else if (push) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fw_r <= fw_nxt;
    end
  end

endmodule

### design/pcpt_queue.sv
// ----------------------------------------------------------------------------
// pcpt_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pcpt_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  pcpt_pkg::word_t                 push_word,
  input  logic                            pop,
  output pcpt_pkg::word_t                 pop_word,
  output pcpt_pkg::q_status_t             q_status,
  output logic [pcpt_pkg::QCNT_W-1:0]     q_count
);

  pcpt_pkg::word_t                 q_mem [pcpt_pkg::QUEUE_DEPTH];
  logic [pcpt_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [pcpt_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [pcpt_pkg::QCNT_W-1:0]     count_r;
  logic                            do_push;
  logic                            do_pop;

  assign q_status.valid = (count_r != '0);
  assign q_status.full  = (count_r == pcpt_pkg::QCNT_W'(pcpt_pkg::QUEUE_DEPTH));
  assign q_count        = count_r;
  assign pop_word       = q_mem[rd_ptr_r];
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && q_status.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + pcpt_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + pcpt_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + pcpt_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - pcpt_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_word;
    end
  end

endmodule

### design/pcpt_back.sv
// ----------------------------------------------------------------------------
// pcpt_back
// Cloud storage, bounding box tracking and the pair walk: one pair per cycle
// through a read, difference, square and compare pipeline.
// ----------------------------------------------------------------------------
module pcpt_back #(
  parameter int POINTS_PER_CLOUD = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pcpt_pkg::q_status_t             q_status,
  input  pcpt_pkg::word_t                 pop_word,
  output logic                            pop,
  input  logic [pcpt_pkg::LIMIT_W-1:0]    limit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_boxes_overlap,
  output logic                            out_collide
);

  localparam int IW = (POINTS_PER_CLOUD > 1) ? $clog2(POINTS_PER_CLOUD) : 1;
  localparam int CW = $clog2(POINTS_PER_CLOUD + 1);
  localparam int CW_ = pcpt_pkg::COORD_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]                     state_r;
  logic [CW-1:0]                  cnt_r     [2];
  logic                           restart_r [2];
  pcpt_pkg::coord_t               lo_r      [2][3];
  pcpt_pkg::coord_t               hi_r      [2][3];

  logic [pcpt_pkg::POINT_W-1:0]   mem0 [POINTS_PER_CLOUD];
  logic [pcpt_pkg::POINT_W-1:0]   mem1 [POINTS_PER_CLOUD];
  logic [pcpt_pkg::POINT_W-1:0]   rd0_r;
  logic [pcpt_pkg::POINT_W-1:0]   rd1_r;

  logic [IW-1:0]                  i_r;
  logic [IW-1:0]                  j_r;
  logic                           v1_r;
  logic                           v2_r;
  logic                           v3_r;
  logic [CW_-1:0]                 abs_r [3];
  logic [pcpt_pkg::SQ_W-1:0]      sq_r  [3];
  logic                           hit_r;

  logic                           out_valid_r;
  logic                           ov_r;
  logic                           col_r;

  logic                           sel;
  pcpt_pkg::coord_t               pt    [3];
  logic [CW-1:0]                  cnt_eff [2];
  logic                           room    [2];
  logic                           ld      [2];
  logic                           ov;
  logic                           last_i;
  logic                           last_j;
  logic                           drained;
  logic [pcpt_pkg::SUM_W-1:0]     sum;
  logic [CW_:0]                   diff  [3];

  assign out_valid         = out_valid_r;
  assign out_boxes_overlap = ov_r;
  assign out_collide       = col_r;

  assign pop = q_status.valid && (state_r == ST_IDLE) &&
               ((pop_word.kind != pcpt_pkg::KIND_TEST) || !out_valid_r);

  always_comb begin
    case (pop_word.kind)
      pcpt_pkg::KIND_LOAD_SECOND: sel = 1'b1;
      pcpt_pkg::KIND_TEST:        sel = 1'b1;
      default:                    sel = 1'b0;
    endcase
  end

  assign pt[0] = pop_word.x;
  assign pt[1] = pop_word.y;
  assign pt[2] = pop_word.z;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      cnt_eff[c] = restart_r[c] ? '0 : cnt_r[c];
      room[c]    = (cnt_eff[c] < CW'(POINTS_PER_CLOUD));
      ld[c]      = pop && (sel == c[0]);
    end
  end

  always_comb begin
    ov = (cnt_r[0] != '0) && (cnt_r[1] != '0);
    for (int a = 0; a < 3; a++) begin
      if ((hi_r[0][a] < lo_r[1][a]) || (hi_r[1][a] < lo_r[0][a])) begin
        ov = 1'b0;
      end
    end
  end

  assign last_i  = (CW'(i_r) == (cnt_r[0] - CW'(1)));
  assign last_j  = (CW'(j_r) == (cnt_r[1] - CW'(1)));
  assign drained = !v1_r && !v2_r && !v3_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {rd0_r[(2-a)*CW_ + CW_-1], rd0_r[(2-a)*CW_ +: CW_]} -
                {rd1_r[(2-a)*CW_ + CW_-1], rd1_r[(2-a)*CW_ +: CW_]};
    end
  end

  assign sum = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};

  // load bookkeeping and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        cnt_r[c]     <= '0;
        restart_r[c] <= 1'b1;
        for (int a = 0; a < 3; a++) begin
          lo_r[c][a] <= '0;
          hi_r[c][a] <= '0;
        end
      end
    end else begin
      for (int c = 0; c < 2; c++) begin
        if (ld[c]) begin
          restart_r[c] <= pop_word.last;
          if (room[c]) begin
            cnt_r[c] <= cnt_eff[c] + CW'(1);
            for (int a = 0; a < 3; a++) begin
              if (cnt_eff[c] == '0) begin
                lo_r[c][a] <= pt[a];
                hi_r[c][a] <= pt[a];
              end else begin
                if (pt[a] < lo_r[c][a]) lo_r[c][a] <= pt[a];
                if (pt[a] > hi_r[c][a]) hi_r[c][a] <= pt[a];
              end
            end
          end else begin
            cnt_r[c] <= cnt_eff[c];
          end
        end
      end

      v1_r <= (state_r == ST_WALK);
      v2_r <= v1_r;
      v3_r <= v2_r;

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (pop && (pop_word.kind == pcpt_pkg::KIND_TEST)) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (ov) begin
            state_r <= ST_WALK;
          end else begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        ST_WALK: begin
          if (last_j && last_i) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drained) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // walk indices, result payload and datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_CHECK: begin
        i_r   <= '0;
        j_r   <= '0;
        hit_r <= 1'b0;
        if (!ov) begin
          ov_r  <= 1'b0;
          col_r <= 1'b0;
        end
      end
      ST_WALK: begin
        if (last_j) begin
          j_r <= '0;
          if (!last_i) begin
            i_r <= i_r + IW'(1);
          end
        end else begin
          j_r <= j_r + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          ov_r  <= 1'b1;
          col_r <= hit_r;
        end
      end
      default: begin
      end
    endcase

    for (int a = 0; a < 3; a++) begin
      abs_r[a] <= diff[a][CW_] ? CW_'(-diff[a]) : diff[a][CW_-1:0];
      sq_r[a]  <= abs_r[a] * abs_r[a];
    end

    if (v3_r && ({2'b00, sum} < limit)) begin
      hit_r <= 1'b1;
    end
  end

  // point stores
  always_ff @(posedge clk) begin
    if (ld[0] && room[0]) begin
      mem0[cnt_eff[0][IW-1:0]] <= {pop_word.x, pop_word.y, pop_word.z};
    end
    if (ld[1] && room[1]) begin
      mem1[cnt_eff[1][IW-1:0]] <= {pop_word.x, pop_word.y, pop_word.z};
    end
    rd0_r <= mem0[i_r];
    rd1_r <= mem1[j_r];
  end

endmodule

### design/point_cloud_proximity_test.sv
// ----------------------------------------------------------------------------
// point_cloud_proximity_test
// Loads two point clouds, tracks their bounding boxes and, on the last point
// of the second cloud, tests every pair against a squared distance limit.
// Load words pass the front register and the command queue before the store.
// Test word: a load step, a box check, then the pair walk over count0 * count1
// pairs (one pair per cycle) and a pipeline drain; without overlap the result
// follows the check. Reset: counts zero, both clouds restart, limit 65536;
// point stores are not cleared, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module point_cloud_proximity_test #(
  parameter int POINTS_PER_CLOUD = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic signed [15:0]            in_coord_x,
  input  logic signed [15:0]            in_coord_y,
  input  logic signed [15:0]            in_coord_z,
  input  logic                          in_last_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_boxes_overlap,
  output logic                          out_collide,
  input  logic                          cfg_write_en,
  input  logic [35:0]                   cfg_write_data
);

  logic [pcpt_pkg::LIMIT_W-1:0]  limit_r;
  pcpt_pkg::q_status_t           q_status;
  pcpt_pkg::word_t               push_word;
  pcpt_pkg::word_t               pop_word;
  logic                          push;
  logic                          pop;
  logic [pcpt_pkg::QCNT_W-1:0]   q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= pcpt_pkg::LIMIT_RESET;
    end else if (cfg_write_en) begin
      limit_r <= cfg_write_data;
    end
  end

  pcpt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_last_point (in_last_point),
    .q_status      (q_status),
    .push          (push),
    .push_word     (push_word)
  );

  pcpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_status  (q_status),
    .q_count   (q_count)
  );

  pcpt_back #(
    .POINTS_PER_CLOUD (POINTS_PER_CLOUD)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_status          (q_status),
    .pop_word          (pop_word),
    .pop               (pop),
    .limit             (limit_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_boxes_overlap (out_boxes_overlap),
    .out_collide       (out_collide)
  );

`ifndef SYNTHESIS
  a_collide_needs_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_collide) |-> out_boxes_overlap)
    else $error("collision reported without box overlap");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= pcpt_pkg::QCNT_W'(pcpt_pkg::QUEUE_DEPTH))
    else $error("command queue over its depth");

  a_no_output_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result word right after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_status.full)
    else $error("input stalled with queue space left");
`endif

endmodule

### tb/sv/proximity_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// proximity_checker
// Watches the load, result and limit ports of the point cloud proximity test.
// It keeps its own copy of both clouds, their boxes and the squared limit.
// For every closing word of the second cloud it queues the expected verdict,
// compares each delivered verdict field by field, and counts mismatches.
// ----------------------------------------------------------------------------
module proximity_checker #(
  parameter int POINTS_PER_CLOUD = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_operation,
  input  pcpt_pkg::coord_t             in_coord_x,
  input  pcpt_pkg::coord_t             in_coord_y,
  input  pcpt_pkg::coord_t             in_coord_z,
  input  logic                         in_last_point,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_boxes_overlap,
  input  logic                         out_collide,
  input  logic                         cfg_write_en,
  input  logic [pcpt_pkg::LIMIT_W-1:0] cfg_write_data,
  output int                           fail_count,
  output int                           verdicts_pending
);

  typedef struct packed {
    logic overlap;
    logic collide;
  } verdict_t;

  verdict_t expected_verdicts[$];
  verdict_t want;

  pcpt_pkg::coord_t             cloud_pts [2][POINTS_PER_CLOUD][3];
  int                           cloud_count [2];
  int                           box_lo [2][3];
  int                           box_hi [2][3];
  bit                           fresh_load [2];
  logic [pcpt_pkg::LIMIT_W-1:0] limit_sq;

  initial begin
    fail_count = 0;
    verdicts_pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] proximity mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic stash_point(input int sel, input pcpt_pkg::coord_t x,
                             input pcpt_pkg::coord_t y, input pcpt_pkg::coord_t z);
    int p[3];
    int n;
    p[0] = x;
    p[1] = y;
    p[2] = z;
    if (fresh_load[sel]) begin
      fresh_load[sel] = 1'b0;
      cloud_count[sel] = 0;
    end
    n = cloud_count[sel];
    if (n < POINTS_PER_CLOUD) begin
      for (int a = 0; a < 3; a++) begin
        cloud_pts[sel][n][a] = pcpt_pkg::coord_t'(p[a]);
        if (n == 0) begin
          box_lo[sel][a] = p[a];
          box_hi[sel][a] = p[a];
        end else begin
          if (p[a] < box_lo[sel][a]) box_lo[sel][a] = p[a];
          if (p[a] > box_hi[sel][a]) box_hi[sel][a] = p[a];
        end
      end
      cloud_count[sel] = n + 1;
    end
  endtask

  function automatic bit boxes_touch();
    if (cloud_count[0] == 0 || cloud_count[1] == 0) return 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (box_hi[0][a] < box_lo[1][a] || box_hi[1][a] < box_lo[0][a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit pair_within_limit();
    logic [63:0] dsq;
    longint      d;
    for (int i = 0; i < cloud_count[0]; i++) begin
      for (int j = 0; j < cloud_count[1]; j++) begin
        dsq = '0;
        for (int a = 0; a < 3; a++) begin
          d = longint'(cloud_pts[0][i][a]) - longint'(cloud_pts[1][j][a]);
          dsq = dsq + 64'(d * d);
        end
        if (dsq < {28'd0, limit_sq}) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2; k++) begin
        cloud_count[k] = 0;
        fresh_load[k] = 1'b1;
        for (int a = 0; a < 3; a++) begin
          box_lo[k][a] = 0;
          box_hi[k][a] = 0;
        end
      end
      limit_sq = pcpt_pkg::LIMIT_RESET;
      expected_verdicts.delete();
    end else begin
      if (cfg_write_en) limit_sq = cfg_write_data;

      if (in_valid && !in_stall) begin
        stash_point(int'(in_operation), in_coord_x, in_coord_y, in_coord_z);
        if (in_last_point) fresh_load[in_operation] = 1'b1;
        if (in_operation && in_last_point) begin
          want.overlap = boxes_touch();
          want.collide = want.overlap && pair_within_limit();
          expected_verdicts = {expected_verdicts, want};
        end
      end

      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict word with none expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_boxes_overlap !== want.overlap)
            report_mismatch($sformatf("boxes_overlap got %b want %b",
                                      out_boxes_overlap, want.overlap));
          if (out_collide !== want.collide)
            report_mismatch($sformatf("collide got %b want %b",
                                      out_collide, want.collide));
        end
      end
    end
    verdicts_pending <= expected_verdicts.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the point cloud proximity test. A directed set
// covers empty, touching, separated and boundary-distance clouds, then
// phases of clustered random clouds run under different squared limits,
// with random input idle and output stall, and one phase with none.
// A last phase overfills both clouds to walk every stored pair.
// ----------------------------------------------------------------------------
module testbench;

  localparam int POINTS         = 128;
  localparam int LIMIT_W        = pcpt_pkg::LIMIT_W;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_WORDS    = 110;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_operation = 1'b0;
  pcpt_pkg::coord_t   in_coord_x = '0;
  pcpt_pkg::coord_t   in_coord_y = '0;
  pcpt_pkg::coord_t   in_coord_z = '0;
  logic               in_last_point = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_boxes_overlap;
  logic               out_collide;
  logic               cfg_write_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_write_data = '0;

  int fail_count;
  int verdicts_pending;
  int quiet_cycles = 0;
  int words_sent = 0;
  bit calm = 1'b0;

  point_cloud_proximity_test #(
    .POINTS_PER_CLOUD(POINTS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_last_point    (in_last_point),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_boxes_overlap(out_boxes_overlap),
    .out_collide      (out_collide),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data)
  );

  proximity_checker #(
    .POINTS_PER_CLOUD(POINTS)
  ) proximity_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_last_point    (in_last_point),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_boxes_overlap(out_boxes_overlap),
    .out_collide      (out_collide),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(input bit op, input int x, input int y, input int z,
                           input bit last);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_coord_x    <= pcpt_pkg::coord_t'(x);
    in_coord_y    <= pcpt_pkg::coord_t'(y);
    in_coord_z    <= pcpt_pkg::coord_t'(z);
    in_last_point <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  function automatic int near(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(4))
      0: return 8;
      1: return 64;
      2: return 512;
      3: return 4096;
      default: return 65535;
    endcase
  endfunction

  task automatic send_cloud(input bit op, input int n, input int cx, input int cy,
                            input int cz, input int spread, input bit close);
    for (int i = 0; i < n; i++) begin
      send_word(op, near(cx, spread), near(cy, spread), near(cz, spread),
                close && (i == n - 1));
    end
  endtask

  task automatic random_phase();
    int start;
    int r;
    int cx, cy, cz, spread;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) begin
      r      = $urandom_range(99);
      cx     = int'($urandom_range(65535)) - 32768;
      cy     = int'($urandom_range(65535)) - 32768;
      cz     = int'($urandom_range(65535)) - 32768;
      spread = pick_spread();
      if (r < 70) begin
        if ($urandom_range(1)) send_cloud(1'b0, $urandom_range(1, 8), cx, cy, cz, spread, 1'b1);
        send_cloud(1'b1, $urandom_range(1, 8), cx, cy, cz, spread, 1'b1);
      end else if (r < 82) begin
        send_word(1'($urandom_range(1)), int'($urandom_range(65535)) - 32768,
                  int'($urandom_range(65535)) - 32768,
                  int'($urandom_range(65535)) - 32768, 1'($urandom_range(1)));
      end else if (r < 91) begin
        // first cloud left open, the test takes what it holds
        send_cloud(1'b0, $urandom_range(1, 4), cx, cy, cz, spread, 1'b0);
        send_cloud(1'b1, $urandom_range(1, 4), cx, cy, cz, spread, 1'b1);
      end else begin
        send_cloud(1'b1, $urandom_range(1, 3), cx, cy, cz, spread, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty first cloud
    send_word(1'b1, 0, 0, 0, 1'b1);
    // full-range first box, boundary distances at the reset limit
    send_word(1'b0, -32768, -32768, -32768, 1'b0);
    send_word(1'b0, 32767, 32767, 32767, 1'b1);
    send_word(1'b1, -32768, -32768, -32767, 1'b1);
    send_word(1'b1, 32767, 32767, 32511, 1'b1);
    send_word(1'b1, 32767, 32767, 32512, 1'b1);
    send_word(1'b1, 0, 0, 0, 1'b0);
    send_word(1'b1, 100, -50, 7, 1'b1);
    // touching and separated boxes
    send_word(1'b0, 0, 0, 0, 1'b0);
    send_word(1'b0, 100, 100, 100, 1'b1);
    send_word(1'b1, 100, 100, 100, 1'b0);
    send_word(1'b1, 200, 200, 200, 1'b1);
    send_word(1'b1, 101, 50, 50, 1'b0);
    send_word(1'b1, 200, 60, 60, 1'b1);
    send_word(1'b1, 50, -1, 50, 1'b1);
    // open first cloud, then closed later
    send_word(1'b0, 1000, 1000, 1000, 1'b0);
    send_word(1'b1, 1000, 1000, 1255, 1'b1);
    send_word(1'b0, -1000, -1000, -1000, 1'b1);
    send_word(1'b1, 0, 0, 0, 1'b1);

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_limit('0);
        1: set_limit({LIMIT_W{1'b1}});
        2: set_limit(LIMIT_W'(65536));
        3: set_limit(LIMIT_W'(1));
        4: set_limit(LIMIT_W'($urandom_range(1 << 20)));
        5: set_limit({4'($urandom_range(15)), 32'($urandom)});
        default: set_limit(LIMIT_W'($urandom_range(1 << 24)));
      endcase
      calm = (phase == 3);
      random_phase();
    end
    calm = 1'b0;

    // both clouds past capacity, full pair walk
    set_limit(LIMIT_W'(65536));
    send_cloud(1'b0, POINTS + 2, 0, 0, 0, 65535, 1'b1);
    send_cloud(1'b1, POINTS + 2, 0, 0, 0, 65535, 1'b1);
    send_cloud(1'b0, POINTS + 1, 5000, -5000, 300, 4096, 1'b1);
    send_cloud(1'b1, POINTS + 1, 5000, -5000, 300, 4096, 1'b1);

    wait_idle();
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
